### sv/mlcg_pkg.sv
// ============================================================================
// mlcg_pkg
// Shared types and constants for the minimal standard LCG sampler.
// ============================================================================
package mlcg_pkg;

    localparam int unsigned VAL_W = 31;
    localparam int unsigned MUL_W = 15;
    localparam int unsigned PROD_W = VAL_W + MUL_W;
    localparam int unsigned SUM_W = 35;
    localparam int unsigned CNT_W = 4;

    localparam int unsigned MAX_CATEGORIES = 8;
    localparam int unsigned AW = (MAX_CATEGORIES > 1) ? $clog2(MAX_CATEGORIES) : 1;

    localparam logic [MUL_W-1:0] MULTIPLIER = 15'd16807;
    localparam logic [VAL_W-1:0] MODULUS = 31'h7FFF_FFFF;
    localparam logic [SUM_W-1:0] NEG_MODULUS = ~{4'b0000, MODULUS} + 35'd1;

    localparam logic [1:0] FUNC_UNIFORM = 2'd0;
    localparam logic [1:0] FUNC_CATEG = 2'd1;
    localparam logic [1:0] FUNC_BERN = 2'd2;
    localparam logic [1:0] FUNC_LOAD = 2'd3;

    localparam logic [1:0] REG_SEED = 2'd0;
    localparam logic [1:0] REG_THRESH = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_MUL    = 3'd1,
        OP_FOLD   = 3'd2,
        OP_REDUCE = 3'd3,
        OP_ACCUM  = 3'd4,
        OP_BERN   = 3'd5
    } op_t;

    typedef struct packed {
        op_t  op;
        logic clear_acc;
    } dp_cmd_t;

endpackage

### sv/mlcg_wram.sv
// ============================================================================
// mlcg_wram
// Category weight memory: one write port, one registered read port.
// ============================================================================
module mlcg_wram #(
    parameter int unsigned DEPTH = 8
) (
    input  logic                                          aclk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [mlcg_pkg::VAL_W-1:0]                    wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [mlcg_pkg::VAL_W-1:0]                    rdata
);

    logic [mlcg_pkg::VAL_W-1:0] mem [DEPTH];
    logic [mlcg_pkg::VAL_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/mlcg_datapath.sv
// ============================================================================
// mlcg_datapath
// Generator value, 31x15 multiplier and shared 35-bit add/compare unit.
// ============================================================================
module mlcg_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mlcg_pkg::dp_cmd_t           cmd,
    input  logic [mlcg_pkg::VAL_W-1:0]  weight,
    input  logic [mlcg_pkg::VAL_W-1:0]  threshold,
    input  logic                        seed_we,
    input  logic [mlcg_pkg::VAL_W-1:0]  seed,
    output logic [mlcg_pkg::VAL_W-1:0]  value,
    output logic                        le
);

    logic [mlcg_pkg::VAL_W-1:0]  x_reg, x_next;
    logic [mlcg_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [mlcg_pkg::SUM_W-1:0]  acc_reg, acc_next;
    logic [mlcg_pkg::SUM_W-1:0]  add_a, add_b, add_sum, cmp_b;

    always_comb begin
        add_a = acc_reg;
        add_b = '0;
        unique case (cmd.op)
            mlcg_pkg::OP_FOLD: begin
                add_a = mlcg_pkg::SUM_W'(prod_reg[mlcg_pkg::VAL_W-1:0]);
                add_b = mlcg_pkg::SUM_W'(prod_reg[mlcg_pkg::PROD_W-1:mlcg_pkg::VAL_W]);
            end
            mlcg_pkg::OP_REDUCE: add_b = mlcg_pkg::NEG_MODULUS;
            mlcg_pkg::OP_ACCUM:  add_b = mlcg_pkg::SUM_W'(weight);
            default:             add_b = '0;
        endcase
    end

    assign add_sum = add_a + add_b;
    assign cmp_b   = (cmd.op == mlcg_pkg::OP_ACCUM) ? add_sum
                                                    : mlcg_pkg::SUM_W'(threshold);
    assign le      = mlcg_pkg::SUM_W'(x_reg) <= cmp_b;

    always_comb begin
        x_next    = x_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        if (cmd.op == mlcg_pkg::OP_MUL) begin
            prod_next = x_reg * mlcg_pkg::MULTIPLIER;
        end
        if (cmd.op == mlcg_pkg::OP_REDUCE) begin
            // negative difference means the folded value is already below the modulus
            x_next = add_sum[mlcg_pkg::SUM_W-1] ? acc_reg[mlcg_pkg::VAL_W-1:0]
                                                : add_sum[mlcg_pkg::VAL_W-1:0];
        end
        if (cmd.op == mlcg_pkg::OP_FOLD || cmd.op == mlcg_pkg::OP_ACCUM) begin
            acc_next = add_sum;
        end else if (cmd.clear_acc) begin
            acc_next = '0;
        end
        if (seed_we) begin
            x_next = seed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg <= mlcg_pkg::VAL_W'(1);
        end else begin
            x_reg <= x_next;
        end
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign value = x_reg;

endmodule

### sv/mlcg_ctrl.sv
// ============================================================================
// mlcg_ctrl
// Sequencer: request intake, weight walk and result register.
// ============================================================================
module mlcg_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_func,
    input  logic [2:0]                  s_entry_index,
    input  logic [mlcg_pkg::VAL_W-1:0]  s_weight_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [mlcg_pkg::VAL_W-1:0]  m_random_value,
    output logic [3:0]                  m_category,
    output logic                        m_flag,
    input  logic [mlcg_pkg::CNT_W-1:0]  category_count,
    input  logic [mlcg_pkg::VAL_W-1:0]  value,
    input  logic                        le,
    output mlcg_pkg::dp_cmd_t           cmd,
    output logic                        ram_we,
    output logic [mlcg_pkg::AW-1:0]     ram_waddr,
    output logic [mlcg_pkg::VAL_W-1:0]  ram_wdata,
    output logic [mlcg_pkg::AW-1:0]     ram_raddr
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MUL    = 6'b000010,
        ST_FOLD   = 6'b000100,
        ST_REDUCE = 6'b001000,
        ST_WALK   = 6'b010000,
        ST_FIN    = 6'b100000
    } state_t;

    state_t                      state_reg, state_next;
    logic [1:0]                  func_reg, func_next;
    logic [mlcg_pkg::CNT_W-1:0]  cnt_reg, cnt_next, cnt_inc;
    logic [3:0]                  cat_reg, cat_next;
    logic [mlcg_pkg::CNT_W-1:0]  n_used;
    logic                        m_valid_reg, m_valid_next;
    logic [mlcg_pkg::VAL_W-1:0]  m_value_reg, m_value_next;
    logic [3:0]                  m_cat_reg, m_cat_next;
    logic                        m_flag_reg, m_flag_next;
    logic [mlcg_pkg::AW+2:0]     waddr_wide;
    logic [mlcg_pkg::AW+mlcg_pkg::CNT_W-1:0] raddr_wide;
    logic                        idx_ok;

    assign n_used = (32'(category_count) > mlcg_pkg::MAX_CATEGORIES)
                    ? mlcg_pkg::CNT_W'(mlcg_pkg::MAX_CATEGORIES) : category_count;
    assign cnt_inc = cnt_reg + mlcg_pkg::CNT_W'(1);

    assign waddr_wide = {{mlcg_pkg::AW{1'b0}}, s_entry_index};
    assign raddr_wide = {{mlcg_pkg::AW{1'b0}}, cnt_next};
    assign ram_waddr  = waddr_wide[mlcg_pkg::AW-1:0];
    assign ram_raddr  = raddr_wide[mlcg_pkg::AW-1:0];
    assign ram_wdata  = s_weight_value;
    assign idx_ok     = 32'(s_entry_index) < mlcg_pkg::MAX_CATEGORIES;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        func_next     = func_reg;
        cnt_next      = cnt_reg;
        cat_next      = cat_reg;
        cmd.op        = mlcg_pkg::OP_NONE;
        cmd.clear_acc = 1'b0;
        ram_we        = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_value_next  = m_value_reg;
        m_cat_next    = m_cat_reg;
        m_flag_next   = m_flag_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    func_next = s_func;
                    if (s_func == mlcg_pkg::FUNC_LOAD) begin
                        ram_we     = idx_ok;
                        cat_next   = 4'd0;
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                cmd.op     = mlcg_pkg::OP_MUL;
                state_next = ST_FOLD;
            end
            ST_FOLD: begin
                cmd.op     = mlcg_pkg::OP_FOLD;
                state_next = ST_REDUCE;
            end
            ST_REDUCE: begin
                cmd.op        = mlcg_pkg::OP_REDUCE;
                cmd.clear_acc = 1'b1;
                cnt_next      = '0;
                cat_next      = (func_reg == mlcg_pkg::FUNC_CATEG) ? 4'd1 : 4'd0;
                if (func_reg == mlcg_pkg::FUNC_CATEG && n_used != '0) begin
                    state_next = ST_WALK;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_WALK: begin
                cmd.op = mlcg_pkg::OP_ACCUM;
                if (le) begin
                    cat_next   = 4'(cnt_inc);
                    state_next = ST_FIN;
                end else if (cnt_inc == n_used) begin
                    cat_next   = 4'(n_used + mlcg_pkg::CNT_W'(1));
                    state_next = ST_FIN;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            ST_FIN: begin
                cmd.op = (func_reg == mlcg_pkg::FUNC_BERN) ? mlcg_pkg::OP_BERN
                                                           : mlcg_pkg::OP_NONE;
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_value_next = value;
                    m_cat_next   = cat_reg;
                    m_flag_next  = (func_reg == mlcg_pkg::FUNC_BERN) && le;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        func_reg    <= func_next;
        cnt_reg     <= cnt_next;
        cat_reg     <= cat_next;
        m_value_reg <= m_value_next;
        m_cat_reg   <= m_cat_next;
        m_flag_reg  <= m_flag_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_random_value = m_value_reg;
    assign m_category     = m_cat_reg;
    assign m_flag         = m_flag_reg;

endmodule

### sv/minimal_standard_lcg_sampler.sv
// ============================================================================
// minimal_standard_lcg_sampler
// Park-Miller (16807, 2^31-1) generator with uniform, categorical and
// Bernoulli draws and a loadable category weight table.
// ============================================================================
// Requests enter on s_valid/s_ready with s_func, s_entry_index and
// s_weight_value; results leave on m_valid/m_ready with m_random_value,
// m_category and m_flag, one result per request, in order.
// Registers over APB: seed at 0x0 (also loads the generator), true_threshold
// at 0x4, category_count at 0x8. pready is tied high.
// Steps from request accept to m_valid:
//   load weight              final step
//   uniform, Bernoulli draw  multiply, fold, reduce, final step
//   categorical draw         adds a walk of k = 0..8 weights before final step
// A new request is taken only once the previous result is registered. The
// sequence is set by the single multiplier, the shared 35-bit
// adder/comparator and the one-read-per-cycle weight memory, which is walked
// one entry per cycle.
// Reset: seed 1, threshold 0, count 0, generator 1; weights are undefined
// until loaded. A stalled result stays in the output register; the next
// request is still accepted and waits in its final step until the register
// frees up.
// ============================================================================
module minimal_standard_lcg_sampler (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_func,
    input  logic [2:0]                  s_entry_index,
    input  logic [mlcg_pkg::VAL_W-1:0]  s_weight_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [mlcg_pkg::VAL_W-1:0]  m_random_value,
    output logic [3:0]                  m_category,
    output logic                        m_flag
);

    logic [mlcg_pkg::VAL_W-1:0] seed_reg, seed_next;
    logic [mlcg_pkg::VAL_W-1:0] thresh_reg, thresh_next;
    logic [mlcg_pkg::CNT_W-1:0] count_reg, count_next;
    logic                       cfg_we, seed_we;
    logic [1:0]                 reg_idx;

    mlcg_pkg::dp_cmd_t          cmd;
    logic [mlcg_pkg::VAL_W-1:0] value;
    logic                       le;
    logic                       ram_we;
    logic [mlcg_pkg::AW-1:0]    ram_waddr, ram_raddr;
    logic [mlcg_pkg::VAL_W-1:0] ram_wdata, ram_rdata;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_we  = psel && penable && pwrite;
    assign seed_we = cfg_we && (reg_idx == mlcg_pkg::REG_SEED);

    always_comb begin
        seed_next   = seed_reg;
        thresh_next = thresh_reg;
        count_next  = count_reg;
        if (cfg_we) begin
            unique case (reg_idx)
                mlcg_pkg::REG_SEED:   seed_next   = pwdata[mlcg_pkg::VAL_W-1:0];
                mlcg_pkg::REG_THRESH: thresh_next = pwdata[mlcg_pkg::VAL_W-1:0];
                mlcg_pkg::REG_COUNT:  count_next  = pwdata[mlcg_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            mlcg_pkg::REG_SEED:   prdata = 32'(seed_reg);
            mlcg_pkg::REG_THRESH: prdata = 32'(thresh_reg);
            mlcg_pkg::REG_COUNT:  prdata = 32'(count_reg);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg   <= mlcg_pkg::VAL_W'(1);
            thresh_reg <= '0;
            count_reg  <= '0;
        end else begin
            seed_reg   <= seed_next;
            thresh_reg <= thresh_next;
            count_reg  <= count_next;
        end
    end

    mlcg_wram #(
        .DEPTH (mlcg_pkg::MAX_CATEGORIES)
    ) u_wram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mlcg_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .weight    (ram_rdata),
        .threshold (thresh_reg),
        .seed_we   (seed_we),
        .seed      (pwdata[mlcg_pkg::VAL_W-1:0]),
        .value     (value),
        .le        (le)
    );

    mlcg_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_entry_index  (s_entry_index),
        .s_weight_value (s_weight_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_random_value (m_random_value),
        .m_category     (m_category),
        .m_flag         (m_flag),
        .category_count (count_reg),
        .value          (value),
        .le             (le),
        .cmd            (cmd),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_raddr      (ram_raddr)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("sampler still ready after taking a request");

    a_cat_flag_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_category != 4'd0 && m_flag))
        else $error("category and flag both set in one result");

    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

### tb/tb_minimal_standard_lcg_sampler.sv
// ============================================================================
// tb_minimal_standard_lcg_sampler
// Self-checking bench for the minimal standard LCG sampler.
// ============================================================================
// A short table of directed requests and register writes covers reset
// values, zero and saturated category counts, the stuck-at-zero seeds, the
// "no category" outcome and the field extremes. Four random phases follow,
// each with its own register settings and its own sender idle and receiver
// stall rates. Every result is checked field by field, against an in-bench
// model of the generator, threshold and weight table or a directed value.
// ============================================================================
module tb_minimal_standard_lcg_sampler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_CATEGORIES = mlcg_pkg::MAX_CATEGORIES;
    localparam int unsigned RANDOM_PER_PHASE = 500;
    localparam int unsigned STALL_LIMIT = 5000;
    localparam logic [mlcg_pkg::VAL_W-1:0] MAX31 = 31'h7FFF_FFFF;
    localparam logic [mlcg_pkg::PROD_W-1:0] LCG_MULT = 46'd16807;

    typedef struct packed {
        logic [mlcg_pkg::VAL_W-1:0] value;
        logic [3:0]                 category;
        logic                       flag;
    } sample_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  code;
        logic [2:0]  index;
        logic [31:0] data;
        logic        checked;
        sample_t     sample;
    } row_t;

    logic                       aclk;
    logic                       aresetn = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [3:0]                 paddr = '0;
    logic [31:0]                pwdata = '0;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [1:0]                 s_func = mlcg_pkg::FUNC_UNIFORM;
    logic [2:0]                 s_entry_index = '0;
    logic [mlcg_pkg::VAL_W-1:0] s_weight_value = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [mlcg_pkg::VAL_W-1:0] m_random_value;
    logic [3:0]                 m_category;
    logic                       m_flag;

    // generator model
    logic [mlcg_pkg::VAL_W-1:0] gen_value = 31'd1;
    logic [mlcg_pkg::VAL_W-1:0] bern_threshold = '0;
    logic [3:0]                 cat_count = '0;
    logic [mlcg_pkg::VAL_W-1:0] weights [MAX_CATEGORIES];

    sample_t     expected_samples [$];
    row_t        directed_rows [$];
    int unsigned error_count = 0;
    int unsigned idle_pct = 30;
    int unsigned stall_pct = 30;
    int unsigned quiet_cycles = 0;

    minimal_standard_lcg_sampler DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_entry_index (s_entry_index),
        .s_weight_value(s_weight_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_random_value(m_random_value),
        .m_category    (m_category),
        .m_flag        (m_flag)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [mlcg_pkg::VAL_W-1:0] lcg_step(
            input logic [mlcg_pkg::VAL_W-1:0] x);
        logic [mlcg_pkg::PROD_W-1:0] prod;
        logic [mlcg_pkg::VAL_W:0]    folded;
        prod = x * LCG_MULT;
        folded = prod[mlcg_pkg::VAL_W-1:0] + prod[mlcg_pkg::PROD_W-1:mlcg_pkg::VAL_W];
        if (folded >= {1'b0, MAX31}) begin
            folded = folded - {1'b0, MAX31};
        end
        return folded[mlcg_pkg::VAL_W-1:0];
    endfunction

    function automatic sample_t predict_sample(input logic [1:0] f, input logic [2:0] ix,
                                               input logic [mlcg_pkg::VAL_W-1:0] w);
        sample_t     res;
        logic [35:0] running;
        int unsigned n;
        logic        found;
        res = '0;
        if (f == mlcg_pkg::FUNC_LOAD) begin
            if (ix < MAX_CATEGORIES) begin
                weights[ix] = w;
            end
        end else begin
            gen_value = lcg_step(gen_value);
            if (f == mlcg_pkg::FUNC_CATEG) begin
                n = (cat_count > MAX_CATEGORIES) ? MAX_CATEGORIES : cat_count;
                res.category = 4'(n + 1);
                running = '0;
                found = 1'b0;
                for (int i = 0; i < n; i++) begin
                    running = running + weights[i];
                    if (!found && gen_value <= running) begin
                        res.category = 4'(i + 1);
                        found = 1'b1;
                    end
                end
            end else if (f == mlcg_pkg::FUNC_BERN) begin
                res.flag = (gen_value <= bern_threshold);
            end
        end
        res.value = gen_value;
        return res;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_result();
        sample_t exp_s;
        if (expected_samples.size() == 0) begin
            report_error($sformatf("result with no request pending: value %0d",
                                   m_random_value));
        end else begin
            exp_s = expected_samples.pop_front();
            if (m_random_value !== exp_s.value)
                report_error($sformatf("random_value %0d, expected %0d",
                                       m_random_value, exp_s.value));
            if (m_category !== exp_s.category)
                report_error($sformatf("category %0d, expected %0d",
                                       m_category, exp_s.category));
            if (m_flag !== exp_s.flag)
                report_error($sformatf("flag %0b, expected %0b", m_flag, exp_s.flag));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_result();
        end
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            mlcg_pkg::REG_SEED: gen_value = data[mlcg_pkg::VAL_W-1:0];
            mlcg_pkg::REG_THRESH: bern_threshold = data[mlcg_pkg::VAL_W-1:0];
            mlcg_pkg::REG_COUNT: cat_count = data[3:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic wait_for_results();
        while (expected_samples.size() != 0) @(posedge aclk);
    endtask

    task automatic send_request(input logic [1:0] f, input logic [2:0] ix,
                                input logic [mlcg_pkg::VAL_W-1:0] w, input logic checked,
                                input sample_t typed);
        sample_t predicted;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= f;
        s_entry_index <= ix;
        s_weight_value <= w;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_sample(f, ix, w);
        expected_samples.push_back(checked ? typed : predicted);
    endtask

    task automatic add_request(input logic [1:0] f, input logic [2:0] ix,
                               input logic [mlcg_pkg::VAL_W-1:0] w);
        directed_rows.push_back('{ROW_REQ, f, ix, {1'b0, w}, 1'b0, '0});
    endtask

    task automatic add_checked(input logic [1:0] f, input logic [2:0] ix,
                               input logic [mlcg_pkg::VAL_W-1:0] w,
                               input logic [mlcg_pkg::VAL_W-1:0] value,
                               input logic [3:0] cat, input logic flag);
        sample_t s;
        s.value = value;
        s.category = cat;
        s.flag = flag;
        directed_rows.push_back('{ROW_REQ, f, ix, {1'b0, w}, 1'b1, s});
    endtask

    task automatic add_setting(input logic [1:0] idx, input logic [31:0] data);
        directed_rows.push_back('{ROW_CFG, idx, 3'd0, data, 1'b0, '0});
    endtask

    task automatic build_directed_rows();
        // after reset: seed 1, count 0, threshold 0
        add_checked(mlcg_pkg::FUNC_UNIFORM, 3'd0, '0, 31'd16807, 4'd0, 1'b0);
        add_checked(mlcg_pkg::FUNC_CATEG, 3'd7, MAX31, 31'd282475249, 4'd1, 1'b0);
        add_checked(mlcg_pkg::FUNC_BERN, 3'd0, '0, 31'd1622650073, 4'd0, 1'b0);
        add_request(mlcg_pkg::FUNC_LOAD, 3'd0, 31'h0000_0000);
        add_request(mlcg_pkg::FUNC_LOAD, 3'd1, MAX31);
        add_request(mlcg_pkg::FUNC_LOAD, 3'd2, 31'h0000_0001);
        add_request(mlcg_pkg::FUNC_LOAD, 3'd3, 31'h2AAA_AAAA);
        add_request(mlcg_pkg::FUNC_LOAD, 3'd4, 31'h5555_5555);
        add_request(mlcg_pkg::FUNC_LOAD, 3'd5, 31'h1000_0000);
        add_request(mlcg_pkg::FUNC_LOAD, 3'd6, 31'h0FFF_FFFF);
        add_request(mlcg_pkg::FUNC_LOAD, 3'd7, 31'h4000_0000);
        add_setting(mlcg_pkg::REG_COUNT, 32'd8);
        add_request(mlcg_pkg::FUNC_CATEG, 3'd0, '0);
        // count saturates at table size
        add_setting(mlcg_pkg::REG_COUNT, 32'd15);
        add_request(mlcg_pkg::FUNC_CATEG, 3'd0, '0);
        add_setting(mlcg_pkg::REG_THRESH, {1'b0, MAX31});
        add_request(mlcg_pkg::FUNC_BERN, 3'd0, '0);
        // degenerate seeds lock the generator at zero
        add_setting(mlcg_pkg::REG_SEED, 32'd0);
        add_checked(mlcg_pkg::FUNC_UNIFORM, 3'd0, '0, '0, 4'd0, 1'b0);
        add_checked(mlcg_pkg::FUNC_BERN, 3'd0, '0, '0, 4'd0, 1'b1);
        add_setting(mlcg_pkg::REG_SEED, 32'hFFFF_FFFF);
        add_checked(mlcg_pkg::FUNC_CATEG, 3'd0, '0, '0, 4'd1, 1'b0);
        add_checked(mlcg_pkg::FUNC_LOAD, 3'd1, 31'd5, '0, 4'd0, 1'b0);
        // small weights: no category reached
        add_setting(mlcg_pkg::REG_SEED, {1'b0, MAX31 - 31'd1});
        add_setting(mlcg_pkg::REG_COUNT, 32'd2);
        add_request(mlcg_pkg::FUNC_CATEG, 3'd0, '0);
        add_request(mlcg_pkg::FUNC_UNIFORM, 3'd0, '0);
        add_setting(mlcg_pkg::REG_THRESH, 32'd0);
        add_request(mlcg_pkg::FUNC_BERN, 3'd0, '0);
    endtask

    task automatic send_random_request();
        logic [1:0]                 f;
        logic [2:0]                 ix;
        logic [mlcg_pkg::VAL_W-1:0] w;
        f = 2'($urandom_range(0, 3));
        ix = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
            0: w = mlcg_pkg::VAL_W'($urandom);
            1: w = mlcg_pkg::VAL_W'($urandom_range(0, 32'h1FFF_FFFF));
            2: w = $urandom_range(0, 1) ? MAX31 : '0;
            default: w = mlcg_pkg::VAL_W'($urandom_range(0, 32'h0FFF_FFFF));
        endcase
        send_request(f, ix, w, 1'b0, '0);
    endtask

    task automatic randomize_settings();
        logic [31:0] seed_val;
        logic [31:0] thresh_val;
        logic [31:0] count_val;
        case ($urandom_range(0, 3))
            0: seed_val = 32'd1;
            1: seed_val = {1'b0, MAX31 - 31'd1};
            default: seed_val = $urandom_range(1, 32'h7FFF_FFFE);
        endcase
        case ($urandom_range(0, 3))
            0: thresh_val = 32'd0;
            1: thresh_val = {1'b0, MAX31};
            default: thresh_val = $urandom & 32'h7FFF_FFFF;
        endcase
        if ($urandom_range(0, 3) == 0) begin
            count_val = $urandom_range(0, 15);
        end else begin
            count_val = $urandom_range(1, MAX_CATEGORIES);
        end
        write_register(mlcg_pkg::REG_SEED, seed_val);
        write_register(mlcg_pkg::REG_THRESH, thresh_val);
        write_register(mlcg_pkg::REG_COUNT, count_val);
    endtask

    initial begin : stimulus
        row_t row;
        foreach (weights[i]) weights[i] = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        build_directed_rows();
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG) begin
                s_valid <= 1'b0;
                wait_for_results();
                write_register(row.code, row.data);
            end else begin
                send_request(row.code, row.index, row.data[mlcg_pkg::VAL_W-1:0],
                             row.checked, row.sample);
            end
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 67; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 67; end
                default: begin idle_pct = 8; stall_pct = 8; end
            endcase
            s_valid <= 1'b0;
            wait_for_results();
            randomize_settings();
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                send_random_request();
            end
        end

        s_valid <= 1'b0;
        wait_for_results();
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
